// ----- rtl/core/ppi_mode0_ata_bridge_top_defines.svh -----
// Assertion macros for the mode-0 parallel port / ATA bridge.
// Used by ppi_mode0_ata_bridge_top; expects i_clk and i_rst_n in scope.
`ifndef PPI_MODE0_ATA_BRIDGE_TOP_DEFINES_SVH
`define PPI_MODE0_ATA_BRIDGE_TOP_DEFINES_SVH

// same-cycle implication
`define PMAB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pmab assertion failed");

// next-cycle implication
`define PMAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pmab assertion failed");

`endif

// ----- rtl/core/pmab_pkg.sv -----
// Shared types and constants of the mode-0 parallel port / ATA bridge.
// No dependencies.
package pmab_pkg;

    // port select codes
    localparam logic [1:0] PORT_A    = 2'd0;
    localparam logic [1:0] PORT_B    = 2'd1;
    localparam logic [1:0] PORT_C    = 2'd2;
    localparam logic [1:0] PORT_CTRL = 2'd3;

    // request type codes
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // port C line layout
    localparam logic [7:0] PC_ADDR_BITS = 8'h07;
    localparam logic [7:0] PC_CS0_BIT   = 8'h08;
    localparam logic [7:0] PC_WR_BIT    = 8'h20;
    localparam logic [7:0] PC_RD_BIT    = 8'h40;

    // control word layout
    localparam logic [7:0] CW_C_LOW_IN  = 8'h01;
    localparam logic [7:0] CW_B_IN      = 8'h02;
    localparam logic [7:0] CW_B_MODE    = 8'h04;
    localparam logic [7:0] CW_C_HIGH_IN = 8'h08;
    localparam logic [7:0] CW_A_IN      = 8'h10;
    localparam logic [7:0] CW_A_MODE    = 8'h60;
    localparam logic [7:0] CW_SET_FLAG  = 8'h80;

    localparam logic [7:0] NIB_LOW  = 8'h0F;
    localparam logic [7:0] NIB_HIGH = 8'hF0;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  port_sel;
        logic [7:0]  write_data;
        logic [15:0] ata_read_word;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        ata_write_strobe;
        logic        ata_read_strobe;
        logic [2:0]  ata_address;
        logic [15:0] ata_write_word;
        logic        mode_error;
    } t_rsp;

endpackage

// ----- rtl/core/pmab_if.sv -----
// Valid/ready channel interfaces for bus requests and results.
// Depends on pmab_pkg.
interface pmab_req_if;
    import pmab_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pmab_rsp_if;
    import pmab_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/ppi_mode0_ata_bridge_top.sv -----
// A request is held in the input register, then moves to the result register, which presents the result.
// One request per clock while results are taken; the port latches and the strobe edge detector
// update in the single cycle a request moves from the input to the result register.
// Reset (synchronous, active low): latches, strobe history and control word go to 0,
// both pipeline registers empty.
// Depends on pmab_pkg, pmab_if and ppi_mode0_ata_bridge_top_defines.svh.
`include "ppi_mode0_ata_bridge_top_defines.svh"

module ppi_mode0_ata_bridge_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmab_req_if.sink    i_req,
    pmab_rsp_if.source  o_rsp
);
    import pmab_pkg::*;

    logic       r_in_valid;
    t_req       r_in;
    logic       r_out_valid;
    t_rsp       r_out;

    logic [7:0] r_a, r_b, r_c, r_ctrl;
    logic [1:0] r_prev;
    logic [7:0] n_a, n_b, n_c, n_ctrl;
    logic [1:0] n_prev;
    t_rsp       n_out;

    logic       advance;
    logic [7:0] outmask;
    logic [7:0] c_new;
    logic       cs0, wr_rise, rd_rise;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.payload = r_out;

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_ctrl  = r_ctrl;
        n_prev  = r_prev;
        n_out   = '0;
        outmask = '0;
        if ((r_ctrl & CW_C_LOW_IN) == 8'h00) outmask = outmask | NIB_LOW;
        if ((r_ctrl & CW_C_HIGH_IN) == 8'h00) outmask = outmask | NIB_HIGH;
        c_new   = (r_c & ~outmask) | (r_in.write_data & outmask);
        cs0     = (c_new & PC_CS0_BIT) != 8'h00;
        wr_rise = ((c_new & PC_WR_BIT) != 8'h00) && !r_prev[0];
        rd_rise = ((c_new & PC_RD_BIT) != 8'h00) && !r_prev[1];

        if (r_in.req_type == REQ_WRITE) begin
            case (r_in.port_sel)
                PORT_A: begin
                    if ((r_ctrl & CW_A_IN) == 8'h00) n_a = r_in.write_data;
                end
                PORT_B: begin
                    if ((r_ctrl & CW_B_IN) == 8'h00) n_b = r_in.write_data;
                end
                PORT_C: begin
                    n_c = c_new;
                    // write goes out with the old {B,A} before a read reloads them
                    if (cs0 && wr_rise) begin
                        n_out.ata_write_strobe = 1'b1;
                        n_out.ata_write_word   = {r_b, r_a};
                    end
                    if (cs0 && rd_rise) begin
                        n_out.ata_read_strobe = 1'b1;
                        n_a = r_in.ata_read_word[7:0];
                        n_b = r_in.ata_read_word[15:8];
                    end
                    if (cs0 && (wr_rise || rd_rise)) begin
                        n_out.ata_address = c_new[2:0] & PC_ADDR_BITS[2:0];
                    end
                    n_prev = {(c_new & PC_RD_BIT) != 8'h00, (c_new & PC_WR_BIT) != 8'h00};
                end
                PORT_CTRL: begin
                    if ((r_in.write_data & CW_SET_FLAG) != 8'h00) begin
                        n_ctrl = r_in.write_data;
                        n_out.mode_error =
                            (r_in.write_data & (CW_A_MODE | CW_B_MODE)) != 8'h00;
                    end
                end
                default: begin
                    n_ctrl = r_ctrl;
                end
            endcase
        end else begin
            case (r_in.port_sel)
                PORT_A: begin
                    if ((r_ctrl & CW_A_IN) != 8'h00) n_out.read_data = r_a;
                end
                PORT_B: begin
                    if ((r_ctrl & CW_B_IN) != 8'h00) n_out.read_data = r_b;
                end
                PORT_C: begin
                    // only input nibbles read back
                    n_out.read_data = r_c & ~outmask;
                end
                PORT_CTRL: begin
                    n_out.read_data = r_ctrl;
                end
                default: begin
                    n_out.read_data = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_a         <= '0;
            r_b         <= '0;
            r_c         <= '0;
            r_ctrl      <= '0;
            r_prev      <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_a         <= n_a;
                r_b         <= n_b;
                r_c         <= n_c;
                r_ctrl      <= n_ctrl;
                r_prev      <= n_prev;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) r_in <= i_req.payload;
        if (advance) r_out <= n_out;
    end

    `PMAB_ASSERT_NOW(a_wword_only_on_strobe,
        r_out_valid && !r_out.ata_write_strobe, r_out.ata_write_word == 16'h0000)
    `PMAB_ASSERT_NOW(a_addr_only_on_strobe,
        r_out_valid && !r_out.ata_write_strobe && !r_out.ata_read_strobe,
        r_out.ata_address == 3'd0)
    `PMAB_ASSERT_NOW(a_merr_needs_set_flag,
        r_out_valid && r_out.mode_error, r_ctrl[7])
    `PMAB_ASSERT_NEXT(a_stalled_request_kept,
        r_in_valid && !advance, r_in_valid && $stable(r_in))

endmodule
